FILE: rtl/mbp_pkg.sv
// Shared types and constants for the MSB-first bit-field packer.
// No dependencies; every other file in rtl refers to this package by scoped names.
`timescale 1ns / 1ps

package mbp_pkg;

	// Default for the widest field the packer accepts.
	localparam int unsigned MAX_FIELD_BITS_DEF = 32;

	localparam int unsigned BYTE_BITS  = 8;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned PEND_W     = 7;  // pending partial-byte bits
	localparam int unsigned CNT_W      = 3;  // pending bit count, 0..7
	localparam int unsigned SAT_W      = 7;  // width used while saturating field_width

	// Job queue between the front and back ends.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_END    = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] field_value;
		logic [5:0]  field_width;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
	} rsp_t;

endpackage

FILE: rtl/mbp_front.sv
// Front end of the bit-field packer: accepts items, merges them with the pending bits
// and hands complete bytes to the job queue. Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_front #(
	parameter int unsigned MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int unsigned ACC_W  = MAX_FIELD_BITS + mbp_pkg::PEND_W,
	localparam int unsigned NBYTES = (MAX_FIELD_BITS + 7) / 8,
	localparam int unsigned DATA_W = NBYTES * mbp_pkg::BYTE_BITS,
	localparam int unsigned NB_W   = $clog2(NBYTES + 1),
	localparam int unsigned WW     = $clog2(MAX_FIELD_BITS + 1),
	localparam int unsigned TW     = $clog2(ACC_W + 1),
	localparam int unsigned EXT_W  = MAX_FIELD_BITS + mbp_pkg::VALUE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  mbp_pkg::req_t        req,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [DATA_W-1:0]    q_data,
	output logic [NB_W-1:0]      q_nbytes
);

	logic [mbp_pkg::PEND_W-1:0] pend_bits_q;
	logic [mbp_pkg::CNT_W-1:0]  pend_cnt_q;

	logic [mbp_pkg::SAT_W-1:0]  fw_ext;
	logic [mbp_pkg::SAT_W-1:0]  fw_sat;
	logic [WW-1:0]              eff_w;
	logic [EXT_W-1:0]           val_ext;
	logic [MAX_FIELD_BITS-1:0]  val_masked;
	logic [ACC_W-1:0]           acc;
	logic [ACC_W-1:0]           aligned;
	logic [TW-1:0]              total;
	logic [2:0]                 rem;
	logic [mbp_pkg::PEND_W-1:0] pend_next;
	logic                       accept;

	assign req_ready = !q_full;
	assign accept    = req_valid && req_ready;

	always_comb begin
		fw_ext = {1'b0, req.field_width};
		fw_sat = (fw_ext > mbp_pkg::SAT_W'(MAX_FIELD_BITS)) ?
			mbp_pkg::SAT_W'(MAX_FIELD_BITS) : fw_ext;

		// An end item behaves as an append of zeros up to the next byte boundary.
		unique case (req.opcode)
			mbp_pkg::OP_APPEND: eff_w = WW'(fw_sat);
			mbp_pkg::OP_END: begin
				if (pend_cnt_q != '0)
					eff_w = WW'(mbp_pkg::BYTE_BITS) - WW'(pend_cnt_q);
				else
					eff_w = '0;
			end
			default: eff_w = '0;
		endcase

		val_ext = EXT_W'(req.field_value);
		for (int i = 0; i < int'(MAX_FIELD_BITS); i++)
			val_masked[i] = val_ext[i] && (i < int'(eff_w)) &&
				(req.opcode == mbp_pkg::OP_APPEND);

		acc       = (ACC_W'(pend_bits_q) << eff_w) | ACC_W'(val_masked);
		total     = TW'(pend_cnt_q) + TW'(eff_w);
		rem       = total[2:0];
		aligned   = acc << (TW'(ACC_W) - total);
		pend_next = mbp_pkg::PEND_W'(acc) & ~({mbp_pkg::PEND_W{1'b1}} << rem);

		q_data   = aligned[ACC_W-1 -: DATA_W];
		q_nbytes = NB_W'(total >> 3);
		q_push   = accept && (q_nbytes != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			unique case (req.opcode) inside
				mbp_pkg::OP_APPEND, mbp_pkg::OP_END: begin
					pend_bits_q <= pend_next;
					pend_cnt_q  <= rem;
				end
				mbp_pkg::OP_BEGIN: begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end
				default: begin
					pend_bits_q <= pend_bits_q;
					pend_cnt_q  <= pend_cnt_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/mbp_queue.sv
// Two-entry job queue between the packer's front and back ends.
// Depends on mbp_pkg for depth and pointer widths.
`timescale 1ns / 1ps

module mbp_queue #(
	parameter int unsigned MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int unsigned NBYTES = (MAX_FIELD_BITS + 7) / 8,
	localparam int unsigned DATA_W = NBYTES * mbp_pkg::BYTE_BITS,
	localparam int unsigned NB_W   = $clog2(NBYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic [NB_W-1:0]   push_nbytes,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output logic [DATA_W-1:0] head_data,
	output logic [NB_W-1:0]   head_nbytes
);

	logic [DATA_W-1:0]          data_mem [mbp_pkg::QUEUE_DEPTH];
	logic [NB_W-1:0]            nb_mem   [mbp_pkg::QUEUE_DEPTH];
	logic [mbp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mbp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mbp_pkg::QCNT_W-1:0] cnt_q;

	assign full        = (cnt_q == mbp_pkg::QCNT_W'(mbp_pkg::QUEUE_DEPTH));
	assign empty       = (cnt_q == '0);
	assign head_data   = data_mem[rd_ptr_q];
	assign head_nbytes = nb_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_mem[wr_ptr_q] <= push_data;
			nb_mem[wr_ptr_q]   <= push_nbytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/mbp_back.sv
// Back end of the bit-field packer: unloads one job at a time from the queue and
// sends its bytes out, one per beat. Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_back #(
	parameter int unsigned MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int unsigned NBYTES = (MAX_FIELD_BITS + 7) / 8,
	localparam int unsigned DATA_W = NBYTES * mbp_pkg::BYTE_BITS,
	localparam int unsigned NB_W   = $clog2(NBYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  logic [DATA_W-1:0] q_data,
	input  logic [NB_W-1:0]   q_nbytes,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mbp_pkg::rsp_t     rsp
);

	logic [DATA_W-1:0] data_q;
	logic [NB_W-1:0]   rem_q;
	logic              beat;

	assign rsp_valid         = (rem_q != '0);
	assign beat              = rsp_valid && rsp_ready;
	assign rsp.out_byte      = data_q[DATA_W-1 -: mbp_pkg::BYTE_BITS];
	assign rsp.last_of_item  = (rem_q == NB_W'(1));

	// Take the next job as soon as the current one has no bytes left after this beat.
	assign q_pop = !q_empty && (!rsp_valid || (rsp.last_of_item && rsp_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rem_q <= '0;
		else if (q_pop)
			rem_q <= q_nbytes;
		else if (beat)
			rem_q <= rem_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			data_q <= q_data;
		else if (beat)
			data_q <= data_q << mbp_pkg::BYTE_BITS;
	end

endmodule

FILE: rtl/msb_first_bitfield_packer.sv
// Top level of the MSB-first bit-field packer.
// Instantiates mbp_front, mbp_queue and mbp_back; types and constants come from mbp_pkg.
`timescale 1ns / 1ps

// The packer turns a stream of variable-width fields into bytes, most significant bit
// first. An append beat adds the low field_width bits of field_value (widths above
// MAX_FIELD_BITS are clamped) to a partial byte of up to seven bits; every byte that
// fills up leaves on the rsp channel. A begin beat drops the partial byte, and an end
// beat sends any partial byte left-aligned and zero-padded, then clears it. The final
// byte that one request produces carries last_of_item; requests that complete no byte
// (begin, short appends, an end with nothing pending, the unused opcode) produce no beat.
// Timing: the front end merges a request with the pending bits in the cycle it is
// accepted and writes the completed bytes, as one job, into a two-entry queue. The back
// end sends one byte per cycle while rsp_ready is high; a request completes up to
// (MAX_FIELD_BITS + 7) / 8 bytes, which is four for 32-bit fields.
// Requests are taken back to back whenever the queue has room. The first byte of a
// request passes through the queue entry and then the back end's output register
// before it appears on rsp, and it waits behind any earlier job. Sustained throughput
// is one output byte per cycle while rsp_ready is high, set by the output shift register.

module msb_first_bitfield_packer #(
	parameter int unsigned MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
	localparam int unsigned NBYTES = (MAX_FIELD_BITS + 7) / 8,
	localparam int unsigned DATA_W = NBYTES * mbp_pkg::BYTE_BITS,
	localparam int unsigned NB_W   = $clog2(NBYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mbp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mbp_pkg::rsp_t rsp
);

	// Job handoff between the front end and the back end.
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic [DATA_W-1:0] push_data;
	logic [NB_W-1:0]   push_nbytes;
	logic [DATA_W-1:0] head_data;
	logic [NB_W-1:0]   head_nbytes;

	// The front end owns the pending partial byte and is the only place that
	// changes it, so begin and end take effect in request order no matter how
	// far behind the output is.
	mbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data),
		.q_nbytes  (push_nbytes)
	);

	// Each queue entry holds the completed bytes of one request, left-aligned,
	// with their count.
	mbp_queue #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (q_push),
		.push_data   (push_data),
		.push_nbytes (push_nbytes),
		.full        (q_full),
		.pop         (q_pop),
		.empty       (q_empty),
		.head_data   (head_data),
		.head_nbytes (head_nbytes)
	);

	// The back end shifts a job out a byte per beat and refills from the queue in
	// the same cycle that the last byte of the previous job leaves.
	mbp_back #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (head_data),
		.q_nbytes  (head_nbytes),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// The queue is never written while full or read while empty.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("job pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("job popped from an empty queue");

	// Bytes of one request leave without gaps: a byte that is not the last of its
	// request is always followed by another valid byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_of_item |=> rsp_valid)
		else $error("request output ended before its last byte");

	// A begin request only clears the pending bits and never queues a job.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.opcode == mbp_pkg::OP_BEGIN) |-> !q_push)
		else $error("begin request produced output bytes");
`endif

endmodule

FILE: bench/tb_msb_first_bitfield_packer.sv
// Self-checking testbench for msb_first_bitfield_packer.
// Depends on rtl/mbp_pkg.sv (request/response structs, opcode enum) and the packer RTL.
`timescale 1ns / 1ps

module tb_msb_first_bitfield_packer;

	// The unused opcode has no enum member in the package; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Widest field the instance accepts; wider requests saturate to this.
	localparam int unsigned FIELD_MAX = mbp_pkg::MAX_FIELD_BITS_DEF;

	localparam int unsigned ITEM_TARGET  = 180;
	localparam int unsigned GAP_MAX      = 19;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned REPORT_MAX   = 10;

	// Scoreboard: mirrors the pending partial byte and queues the bytes every
	// accepted request should produce, then compares output beats in order.
	class packed_byte_board;
		mbp_pkg::rsp_t expected_bytes[$];
		logic [6:0]    pend_bits = '0;
		logic [2:0]    pend_cnt = '0;
		int unsigned   op_seen[4] = '{default: 0};
		int unsigned   bytes_checked = 0;
		int unsigned   errors = 0;

		function void absorb_req(mbp_pkg::req_t r);
			logic [7:0]    acc;
			logic          bit_in;
			int unsigned   cnt;
			int unsigned   w;
			mbp_pkg::rsp_t one;
			mbp_pkg::rsp_t made[$];
			acc = {1'b0, pend_bits};
			cnt = pend_cnt;
			op_seen[r.opcode]++;
			case (r.opcode)
				mbp_pkg::OP_APPEND: begin
					w = (r.field_width > FIELD_MAX) ? FIELD_MAX : r.field_width;
					for (int i = w; i > 0; i--) begin
						bit_in = (i - 1 < mbp_pkg::VALUE_BITS) ?
							r.field_value[i - 1] : 1'b0;
						acc = {acc[6:0], bit_in};
						cnt++;
						if (cnt == 8) begin
							one.out_byte = acc;
							one.last_of_item = 1'b0;
							made.insert(made.size(), one);
							acc = '0;
							cnt = 0;
						end
					end
				end
				mbp_pkg::OP_BEGIN: begin
					acc = '0;
					cnt = 0;
				end
				mbp_pkg::OP_END: begin
					if (cnt > 0) begin
						one.out_byte = acc << (8 - cnt);
						one.last_of_item = 1'b0;
						made.insert(made.size(), one);
					end
					acc = '0;
					cnt = 0;
				end
				default: ;
			endcase
			if (made.size() > 0)
				made[made.size() - 1].last_of_item = 1'b1;
			foreach (made[k])
				expected_bytes.insert(expected_bytes.size(), made[k]);
			pend_bits = acc[6:0];
			pend_cnt = cnt[2:0];
		endfunction

		function void check_byte(mbp_pkg::rsp_t got);
			mbp_pkg::rsp_t want;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("[%0t] ERROR: unexpected beat out_byte=%02h last=%b",
						$time, got.out_byte, got.last_of_item);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.last_of_item !== want.last_of_item) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("[%0t] ERROR: out_byte exp %02h got %02h, last exp %b got %b",
						$time, want.out_byte, got.out_byte,
						want.last_of_item, got.last_of_item);
			end
		endfunction

		function int unsigned outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	mbp_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	mbp_pkg::rsp_t rsp;

	packed_byte_board sb;

	// Shared pacing controls. When no_gaps is set, both sides run flat out so the
	// block sees back-to-back traffic; hold_rsp_long asks the receiver for one
	// long stall so that the job queue fills and req_ready drops.
	bit          no_gaps = 1'b0;
	bit          hold_rsp_long = 1'b0;
	int unsigned items_sent = 0;

	always #1 clk = ~clk;

	msb_first_bitfield_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	function automatic int unsigned draw_gap();
		return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	function automatic mbp_pkg::req_t make_req(logic [1:0] op, logic [31:0] value,
		logic [5:0] width);
		mbp_pkg::req_t r;
		r.opcode = op;
		r.field_value = value;
		r.field_width = width;
		return r;
	endfunction

	// Mostly legal widths with a bias toward short fields, plus the occasional
	// zero-width append and oversized width that the block has to saturate.
	function automatic logic [5:0] draw_width();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 6'($urandom_range(FIELD_MAX + 1, 63));
		if (pick == 1)
			return 6'd0;
		if (pick < 10)
			return 6'($urandom_range(1, 8));
		return 6'($urandom_range(1, FIELD_MAX));
	endfunction

	// Offers one request beat after a random gap and holds it until the block takes
	// it. Inputs move only on the falling edge; the handshake is sampled on the rising edge.
	task automatic send_req(input mbp_pkg::req_t item);
		int unsigned gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.absorb_req(item);
		// Beats the block merely ignores do not count toward the item budget.
		if (!(item.opcode == OP_UNUSED ||
			(item.opcode == mbp_pkg::OP_APPEND && item.field_width == 0)))
			items_sent++;
	endtask

	// Receiver: after each beat it takes, it drops rsp_ready for a random number
	// of cycles, or once for a long stretch when asked to, then waits for data.
	initial begin : rsp_side
		int unsigned gap;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (hold_rsp_long) begin
				gap = LONG_HOLD;
				hold_rsp_long = 1'b0;
			end
			if (gap > 0) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_byte(rsp);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[%0t] ERROR: cycle limit reached with %0d bytes outstanding",
			$time, sb.outstanding());
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned n_fields;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A single bit flushed by end comes out as 0x80, and a
		// second end right after it must produce nothing.
		send_req(make_req(mbp_pkg::OP_BEGIN, 32'h0, 6'd0));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h1, 6'd1));
		send_req(make_req(mbp_pkg::OP_END, 32'h0, 6'd0));
		send_req(make_req(mbp_pkg::OP_END, 32'hFFFF_FFFF, 6'h3F));
		// Full-width fields at both value extremes: four bytes each.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd32));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_0000, 6'd32));
		// Seven pending bits plus a 32-bit field completes four bytes and leaves
		// seven bits, which the end then flushes left-aligned.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_0055, 6'd7));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'hA5C3_0F81, 6'd32));
		send_req(make_req(mbp_pkg::OP_END, 32'h0, 6'd0));
		// A zero-width append adds nothing, even with every value bit set.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd0));
		// Oversized widths saturate to the maximum field size.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'hDEAD_BEEF, 6'h3F));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h1234_5678, 6'd33));
		// The unused opcode leaves the pending bits alone.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_0003, 6'd3));
		send_req(make_req(OP_UNUSED, 32'hFFFF_FFFF, 6'h3F));
		send_req(make_req(mbp_pkg::OP_END, 32'h0, 6'd0));
		// Begin drops a partial byte, so the five bits before it never reach the output.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_001F, 6'd5));
		send_req(make_req(mbp_pkg::OP_BEGIN, 32'hFFFF_FFFF, 6'h3F));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_003C, 6'd8));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_0005, 6'd3));
		send_req(make_req(mbp_pkg::OP_END, 32'h0, 6'd0));
		// Odd widths spanning byte boundaries.
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h7FFF_FFFF, 6'd31));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'hFFFF_8001, 6'd16));
		send_req(make_req(mbp_pkg::OP_APPEND, 32'h0000_00C3, 6'd9));
		send_req(make_req(mbp_pkg::OP_END, 32'h0, 6'd0));

		// Random part: mostly well-formed begin/append.../end structures with
		// random content, some with the end missing, plus bursts of raw noise.
		hold_rsp_long = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4))
					send_req(make_req(2'($urandom_range(0, 3)), $urandom(),
						6'($urandom_range(0, 63))));
			end else begin
				send_req(make_req(mbp_pkg::OP_BEGIN, $urandom(),
					6'($urandom_range(0, 63))));
				n_fields = $urandom_range(1, 8);
				repeat (n_fields)
					send_req(make_req(mbp_pkg::OP_APPEND, $urandom(), draw_width()));
				if ($urandom_range(0, 5) != 0)
					send_req(make_req(mbp_pkg::OP_END, $urandom(),
						6'($urandom_range(0, 63))));
			end
		end
		no_gaps = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		// Let every expected byte arrive, then watch a little longer for strays.
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d appends, %0d begins, %0d ends, %0d unused.",
			sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3],
			sb.op_seen[mbp_pkg::OP_APPEND], sb.op_seen[mbp_pkg::OP_BEGIN],
			sb.op_seen[mbp_pkg::OP_END], sb.op_seen[OP_UNUSED]);
		$display("Checked %0d output bytes, %0d mismatching.", sb.bytes_checked, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
